// ----- rtl/lvbd_pkg.sv -----
package lvbd_pkg;

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int GRAY_W     = 16;
    localparam int LAP_W      = 19;
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int THR_W      = 28;
    localparam int VAR_W      = 28;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [VAR_W-1:0] VAR_MAX = 28'd266342400;

    // luma weights, q8
    localparam logic [GRAY_W-1:0] LUMA_R = 16'd77;
    localparam logic [GRAY_W-1:0] LUMA_G = 16'd150;
    localparam logic [GRAY_W-1:0] LUMA_B = 16'd29;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR_THRESHOLD = 2'd3;

    localparam logic [CFG_SIZE_W-1:0] RST_SIZE = 11'd1024;

    typedef struct packed {
        logic                  color_mode;
        logic [CFG_SIZE_W-1:0] width;
        logic [CFG_SIZE_W-1:0] height;
    } t_pix_cfg;

    typedef enum logic [2:0] {
        PX_IDLE,
        PX_RD_CTR,
        PX_RD_RIGHT,
        PX_RD_OLD,
        PX_WRITE,
        PX_ACC,
        PX_FINISH,
        PX_WAIT_VAR
    } t_pix_state;

    typedef enum logic [2:0] {
        VU_IDLE,
        VU_MUL_SQ,
        VU_MUL_SUM,
        VU_MUL_N,
        VU_CHECK,
        VU_DIV,
        VU_DONE
    } t_var_state;

endpackage

// ----- rtl/lvbd_ram.sv -----
module lvbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/lvbd_pix.sv -----
module lvbd_pix #(
    parameter int MAX_WIDTH  = lvbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lvbd_pkg::DEF_MAX_HEIGHT,
    parameter int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    parameter int SUMW = lvbd_pkg::LAP_W + NW,
    parameter int SQW  = 2 * (lvbd_pkg::LAP_W - 1) + NW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lvbd_pkg::t_pix_cfg            i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lvbd_pkg::PIX_W-1:0]    i_red,
    input  logic [lvbd_pkg::PIX_W-1:0]    i_green,
    input  logic [lvbd_pkg::PIX_W-1:0]    i_blue,
    input  logic                          i_out_busy,
    input  logic                          i_var_done,
    output logic                          o_var_start,
    output logic [NW-1:0]                 o_n,
    output logic signed [SUMW-1:0]        o_sum,
    output logic [SQW-1:0]                o_sumsq
);
    import lvbd_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(2 * MAX_WIDTH);
    localparam int LX  = LAP_W + 2;

    t_pix_state r_state, n_state;

    logic [GRAY_W-1:0] r_gray, r_left, r_ctr, r_right, r_prev_gray, r_prev_upper;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic              r_last;
    logic signed [LAP_W-1:0] r_lap;
    logic signed [SUMW-1:0]  r_sum;
    logic [SQW-1:0]          r_sumsq;

    logic [WCW-1:0] w_w;
    logic [HCW-1:0] w_h;
    logic [GRAY_W-1:0] w_gray;
    logic [AW-1:0]  w_rd_addr, w_wr_addr;
    logic [GRAY_W-1:0] w_rd_data;
    logic           w_wr_en;
    logic signed [LX-1:0] w_lap;
    logic signed [2*LAP_W-1:0] w_sq;
    logic w_interior, w_row_end, w_frame_end, w_row_over;

    // clamp sizes: zero counts as one, large values saturate
    always_comb begin
        if (i_cfg.width == '0) begin
            w_w = WCW'(1);
        end else if (32'(i_cfg.width) > 32'(MAX_WIDTH)) begin
            w_w = WCW'(MAX_WIDTH);
        end else begin
            w_w = WCW'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            w_h = HCW'(1);
        end else if (32'(i_cfg.height) > 32'(MAX_HEIGHT)) begin
            w_h = HCW'(MAX_HEIGHT);
        end else begin
            w_h = HCW'(i_cfg.height);
        end
    end

    assign w_gray = i_cfg.color_mode
                  ? (LUMA_R * GRAY_W'(i_red) + LUMA_G * GRAY_W'(i_green)
                     + LUMA_B * GRAY_W'(i_blue))
                  : {i_red, 8'd0};

    // previous row sits at the opposite parity half
    always_comb begin
        w_rd_addr = '0;
        case (r_state)
            PX_IDLE: begin
                if (r_col >= CW'(2)) begin
                    w_rd_addr = r_row[0] ? AW'(r_col - CW'(2))
                                         : AW'(MAX_WIDTH) + AW'(r_col - CW'(2));
                end
            end
            PX_RD_CTR: begin
                if (r_col >= CW'(1)) begin
                    w_rd_addr = r_row[0] ? AW'(r_col - CW'(1))
                                         : AW'(MAX_WIDTH) + AW'(r_col - CW'(1));
                end
            end
            PX_RD_RIGHT: begin
                w_rd_addr = r_row[0] ? AW'(r_col) : AW'(MAX_WIDTH) + AW'(r_col);
            end
            PX_RD_OLD: begin
                w_rd_addr = r_row[0] ? AW'(MAX_WIDTH) + AW'(r_col) : AW'(r_col);
            end
            default: w_rd_addr = '0;
        endcase
    end

    assign w_wr_addr = r_row[0] ? AW'(MAX_WIDTH) + AW'(r_col) : AW'(r_col);

    lvbd_ram #(
        .WIDTH (GRAY_W),
        .DEPTH (2 * MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_gray),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // laplacian centred one row up, one column left
    assign w_lap = (LX'(r_ctr) <<< 2) - LX'(r_prev_upper) - LX'(r_prev_gray)
                 - LX'(r_left) - LX'(r_right);
    assign w_interior  = (r_row >= RW'(2)) && (r_col >= CW'(2));
    assign w_row_end   = (32'(r_col) + 32'd1) >= 32'(w_w);
    assign w_frame_end = (32'(r_row) + 32'd1) >= 32'(w_h);
    assign w_row_over  = 32'(r_row) >= 32'(w_h);
    assign w_sq        = r_lap * r_lap;

    always_comb begin
        n_state = r_state;
        case (r_state)
            PX_IDLE:     if (i_in_valid) n_state = PX_RD_CTR;
            PX_RD_CTR:   n_state = PX_RD_RIGHT;
            PX_RD_RIGHT: n_state = PX_RD_OLD;
            PX_RD_OLD:   n_state = PX_WRITE;
            PX_WRITE:    n_state = PX_ACC;
            PX_ACC:      n_state = r_last ? PX_FINISH : PX_IDLE;
            PX_FINISH:   if (!i_out_busy) n_state = PX_WAIT_VAR;
            PX_WAIT_VAR: if (i_var_done) n_state = PX_IDLE;
            default:     n_state = PX_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        w_wr_en     = 1'b0;
        o_var_start = 1'b0;
        case (r_state)
            PX_IDLE:   o_in_ready = 1'b1;
            PX_WRITE:  w_wr_en = 1'b1;
            PX_FINISH: o_var_start = !i_out_busy;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_n     = NW'(w_w) * NW'(w_h);
    assign o_sum   = r_sum;
    assign o_sumsq = r_sumsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PX_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_last  <= 1'b0;
            r_sum   <= '0;
            r_sumsq <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                PX_IDLE: begin
                    if (i_in_valid) begin
                        r_gray <= w_gray;
                    end
                end
                PX_RD_CTR:   r_left  <= w_rd_data;
                PX_RD_RIGHT: r_ctr   <= w_rd_data;
                PX_RD_OLD:   r_right <= w_rd_data;
                PX_WRITE: begin
                    r_lap        <= w_interior ? LAP_W'(w_lap) : '0;
                    r_prev_upper <= w_rd_data;
                    r_prev_gray  <= r_gray;
                    r_last       <= 1'b0;
                    if (w_row_end) begin
                        r_col <= '0;
                        if (w_frame_end) begin
                            r_row  <= '0;
                            r_last <= 1'b1;
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                    end else begin
                        r_col <= r_col + CW'(1);
                        if (w_row_over) begin
                            r_row <= RW'(w_h - HCW'(1));
                        end
                    end
                end
                PX_ACC: begin
                    r_sum   <= r_sum + SUMW'(r_lap);
                    r_sumsq <= r_sumsq + SQW'($unsigned(w_sq));
                end
                PX_FINISH: begin
                    if (!i_out_busy) begin
                        r_sum   <= '0;
                        r_sumsq <= '0;
                    end
                end
                default: begin
                    r_last <= r_last;
                end
            endcase
        end
    end
endmodule

// ----- rtl/lvbd_var.sv -----
module lvbd_var #(
    parameter int MAX_WIDTH  = lvbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lvbd_pkg::DEF_MAX_HEIGHT,
    parameter int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    parameter int SUMW = lvbd_pkg::LAP_W + NW,
    parameter int SQW  = 2 * (lvbd_pkg::LAP_W - 1) + NW
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NW-1:0]               i_n,
    input  logic signed [SUMW-1:0]      i_sum,
    input  logic [SQW-1:0]              i_sumsq,
    output logic                        o_done,
    output logic [lvbd_pkg::VAR_W-1:0]  o_variance
);
    import lvbd_pkg::*;

    localparam int NUMW = 2 * SUMW;
    localparam int DW   = NUMW + VAR_W;
    localparam int QCW  = $clog2(VAR_W);

    t_var_state r_state, n_state;

    logic [NW-1:0]    r_n;
    logic [SUMW-1:0]  r_mag, r_mp;
    logic [NUMW-1:0]  r_mc, r_acc, r_prod;
    logic [DW-1:0]    r_rem, r_dv;
    logic [VAR_W-1:0] r_q;
    logic [QCW-1:0]   r_cnt;
    logic [SUMW-1:0]  w_mag;
    logic             w_mul_busy;

    assign w_mag      = i_sum[SUMW-1] ? SUMW'(-i_sum) : SUMW'(i_sum);
    assign w_mul_busy = (r_mp != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            VU_IDLE:    if (i_start) n_state = VU_MUL_SQ;
            VU_MUL_SQ:  if (!w_mul_busy) n_state = VU_MUL_SUM;
            VU_MUL_SUM: begin
                if (!w_mul_busy) begin
                    n_state = (r_prod < r_acc) ? VU_DONE : VU_MUL_N;
                end
            end
            VU_MUL_N:   if (!w_mul_busy) n_state = VU_CHECK;
            VU_CHECK:   n_state = (r_rem >= r_dv) ? VU_DONE : VU_DIV;
            VU_DIV:     if (r_cnt == '0) n_state = VU_DONE;
            VU_DONE:    n_state = VU_IDLE;
            default:    n_state = VU_IDLE;
        endcase
    end

    always_comb begin
        o_done     = (r_state == VU_DONE);
        o_variance = (r_q > VAR_MAX) ? VAR_MAX : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= VU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // shift-add multiplies, then restoring division one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            VU_IDLE: begin
                if (i_start) begin
                    r_n   <= i_n;
                    r_mag <= w_mag;
                    r_mc  <= NUMW'(i_sumsq);
                    r_mp  <= SUMW'(i_n);
                    r_acc <= '0;
                end
            end
            VU_MUL_SQ, VU_MUL_SUM, VU_MUL_N: begin
                if (w_mul_busy) begin
                    r_acc <= r_acc + (r_mp[0] ? r_mc : '0);
                    r_mc  <= r_mc << 1;
                    r_mp  <= r_mp >> 1;
                end else if (r_state == VU_MUL_SQ) begin
                    r_prod <= r_acc;
                    r_mc   <= NUMW'(r_mag);
                    r_mp   <= r_mag;
                    r_acc  <= '0;
                end else if (r_state == VU_MUL_SUM) begin
                    r_rem <= DW'(r_prod - r_acc);
                    r_mc  <= NUMW'(r_n);
                    r_mp  <= SUMW'(r_n);
                    r_acc <= '0;
                    r_q   <= '0;
                end else begin
                    // denominator n*n*256, aligned to the top quotient bit
                    r_dv <= DW'(r_acc) << (8 + VAR_W);
                end
            end
            VU_CHECK: begin
                if (r_rem >= r_dv) begin
                    r_q <= VAR_MAX;
                end else begin
                    r_q   <= '0;
                    r_dv  <= r_dv >> 1;
                    r_cnt <= QCW'(VAR_W - 1);
                end
            end
            VU_DIV: begin
                if (r_rem >= r_dv) begin
                    r_rem <= r_rem - r_dv;
                    r_q   <= {r_q[VAR_W-2:0], 1'b1};
                end else begin
                    r_q <= {r_q[VAR_W-2:0], 1'b0};
                end
                r_dv  <= r_dv >> 1;
                r_cnt <= r_cnt - QCW'(1);
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end
endmodule

// ----- rtl/laplacian_variance_blur_detector.sv -----
// pixel items: four line-memory reads, write-back and accumulate steps per item, on one
//   single-port-read line memory; one item in flight
// frame result: after the last pixel's accept, once the result register is empty
//   (shift-add n*sumsq, squaring the sum, n*n, 28 division steps)
// synchronous active-low reset clears counters, sums and configuration to defaults;
//   the line memory is not cleared
module laplacian_variance_blur_detector #(
    parameter int MAX_WIDTH  = lvbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lvbd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lvbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lvbd_pkg::THR_W-1:0]        i_cfg_data,
    // pixel items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lvbd_pkg::PIX_W-1:0]        i_red,
    input  logic [lvbd_pkg::PIX_W-1:0]        i_green,
    input  logic [lvbd_pkg::PIX_W-1:0]        i_blue,
    // frame result items
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lvbd_pkg::VAR_W-1:0]        o_variance,
    output logic                              o_is_smooth
);
    import lvbd_pkg::*;

    localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUMW = LAP_W + NW;
    localparam int SQW  = 2 * (LAP_W - 1) + NW;

    // configuration registers
    t_pix_cfg         r_cfg;
    logic [THR_W-1:0] r_thr;

    // result register
    logic             r_out_valid;
    logic [VAR_W-1:0] r_variance;
    logic             r_smooth;

    logic                   w_var_start, w_var_done;
    logic [NW-1:0]          w_n;
    logic signed [SUMW-1:0] w_sum;
    logic [SQW-1:0]         w_sumsq;
    logic [VAR_W-1:0]       w_var;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width      <= RST_SIZE;
            r_cfg.height     <= RST_SIZE;
            r_cfg.color_mode <= 1'b1;
            r_thr            <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_cfg.width      <= i_cfg_data[CFG_SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:   r_cfg.height     <= i_cfg_data[CFG_SIZE_W-1:0];
                CFG_COLOR_MODE:     r_cfg.color_mode <= i_cfg_data[0];
                CFG_BLUR_THRESHOLD: r_thr            <= i_cfg_data;
                default:            r_thr            <= r_thr;
            endcase
        end
    end

    // pixel sequencer: gray conversion, line memory, laplacian and running sums
    lvbd_pix #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .NW         (NW),
        .SUMW       (SUMW),
        .SQW        (SQW)
    ) u_pix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_out_busy  (r_out_valid),
        .i_var_done  (w_var_done),
        .o_var_start (w_var_start),
        .o_n         (w_n),
        .o_sum       (w_sum),
        .o_sumsq     (w_sumsq)
    );

    // once-per-frame variance: (n*sumsq - sum^2) / (n^2 * 256)
    lvbd_var #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .NW         (NW),
        .SUMW       (SUMW),
        .SQW        (SQW)
    ) u_var (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_var_start),
        .i_n        (w_n),
        .i_sum      (w_sum),
        .i_sumsq    (w_sumsq),
        .o_done     (w_var_done),
        .o_variance (w_var)
    );

    // the sequencer starts the divider only with this register empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_var_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_var_done) begin
            r_variance <= w_var;
            r_smooth   <= (w_var < r_thr);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_variance  = r_variance;
    assign o_is_smooth = r_smooth;

`ifndef NO_ASSERTIONS
    // a finished frame never overwrites an unread result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_var_done |-> !r_out_valid)
        else $error("frame result overwrote pending item");

    // one pixel at a time: ready drops after an accepted item
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("pixel accepted while previous still in work");

    // variance stays within its saturation bound
    a_var_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_variance <= VAR_MAX))
        else $error("variance above saturation bound");

    // pixel input closed right after a divider start
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_var_start && !w_var_done) |=> !o_in_ready)
        else $error("pixel input open during division");
`endif
endmodule
